FILE: sv/art_pkg.sv
`default_nettype none

package art_pkg;

    localparam logic [1:0] CMD_SEND  = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [3:0] EV_TRACKED     = 4'd0;
    localparam logic [3:0] EV_PASSTHROUGH = 4'd1;
    localparam logic [3:0] EV_REJECTED    = 4'd2;
    localparam logic [3:0] EV_FULL        = 4'd3;
    localparam logic [3:0] EV_ACK_HIT     = 4'd4;
    localparam logic [3:0] EV_ACK_MISS    = 4'd5;
    localparam logic [3:0] EV_RESEND      = 4'd6;
    localparam logic [3:0] EV_DISCONNECT  = 4'd7;
    localparam logic [3:0] EV_TICK_DONE   = 4'd8;

    localparam logic [2:0] REG_TIMEOUT_TICKS    = 3'd0;
    localparam logic [2:0] REG_RETRY_LIMIT      = 3'd1;
    localparam logic [2:0] REG_ACK_CODE         = 3'd2;
    localparam logic [2:0] REG_TAKEOFF_CODE     = 3'd3;
    localparam logic [2:0] REG_LAND_CODE        = 3'd4;
    localparam logic [2:0] REG_INITIAL_SEQUENCE = 3'd5;

    typedef struct packed {
        logic [15:0] sequence_num;
        logic [7:0]  code;
        logic [31:0] param_first;
        logic [31:0] param_second;
        logic [31:0] param_third;
        logic [31:0] start_tick;
        logic [7:0]  tries;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [3:0]  event_res;
        logic [7:0]  event_node;
        logic [15:0] event_sequence;
        logic [7:0]  event_code;
        logic [31:0] param_first;
        logic [31:0] param_second;
        logic [31:0] param_third;
        logic [7:0]  tries_so_far;
        logic        last_of_run;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/art_ram.sv
`default_nettype none

module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/ack_retransmit_tracker.sv
// Tracks sent commands that await an acknowledgement, one compacted FIFO per node.
// Input channel s_*: cmd 0 sends a command, 1 reports a received ack, 2 is a tick.
// Result channel m_*: one or more event transfers per send, ack or tick input;
// m_last_of_run marks the final result of an input item. Configuration is written
// through cfg_wr_en, cfg_index and cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce this. One sequencer and
// one entry RAM port pair serve all commands, so s_ready is low from an accepted
// item until the sequencer is back in idle. A send writes at most one entry; an
// ack reads the node's entries in order until one matches and on a hit shifts each
// later entry down; a tick visits every node, checks only the head entry of each
// node that holds a pending entry and is not disconnected, gives up to two results
// per timed-out entry and ends with a tick-done result.
// A stalled receiver holds the output register; the sequencer waits at the
// next result. Reset (aresetn low, synchronous) empties every FIFO, clears
// disconnect marks, zeroes the tick and sequence counters and restores register
// defaults; a write to initial_sequence loads the sequence counter. No clearing
// pass is needed: per-node fill counts gate every RAM read.
`default_nettype none

module ack_retransmit_tracker #(
    parameter int NUM_NODES     = 8,
    parameter int PENDING_DEPTH = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [7:0]  s_node_id,
    input  wire logic [15:0] s_ack_sequence,
    input  wire logic [7:0]  s_command_code,
    input  wire logic [31:0] s_param_first,
    input  wire logic [31:0] s_param_second,
    input  wire logic [31:0] s_param_third,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_event_res,
    output logic [7:0]       m_event_node,
    output logic [15:0]      m_event_sequence,
    output logic [7:0]       m_event_code,
    output logic [31:0]      m_out_param_first,
    output logic [31:0]      m_out_param_second,
    output logic [31:0]      m_out_param_third,
    output logic [7:0]       m_tries_so_far,
    output logic             m_last_of_run
);

    localparam int NSLOTS = NUM_NODES * PENDING_DEPTH;
    localparam int AW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int NW     = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int NCW    = $clog2(NUM_NODES + 1);
    localparam int CW     = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEND, ST_ACK_RD, ST_ACK_CMP, ST_SH_CHK, ST_SH_RD, ST_SH_WR,
        ST_TK_NODE, ST_TK_CMP, ST_TK_RES
    } state_t;

    state_t               state_reg;
    logic [1:0]           cmd_reg;
    logic [7:0]           node_reg;
    logic                 in_range_reg;
    logic [15:0]          aseq_reg;
    logic [7:0]           code_reg;
    logic [31:0]          p1_reg, p2_reg, p3_reg;
    logic [CW-1:0]        idx_reg;
    logic [NCW-1:0]       nd_reg;
    logic [CW-1:0]        cnt_reg [NUM_NODES];
    logic [NUM_NODES-1:0] disc_reg;
    logic [31:0]          tick_reg;
    logic [15:0]          seq_reg;
    art_pkg::entry_t      ent_reg;
    logic                 rs_pend_reg, dc_pend_reg;
    art_pkg::result_t     out_reg;
    logic                 m_valid_reg;

    logic [15:0] timeout_reg;
    logic [7:0]  retry_reg, ack_code_reg, takeoff_reg, land_reg;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    art_pkg::entry_t  ram_wdata, ram_rdata;
    logic [art_pkg::ENTRY_W-1:0] ram_rbits;

    logic [NW-1:0]   cur_node;
    logic [CW-1:0]   cur_cnt;
    logic            out_free;
    logic            out_load;
    logic            s_accept;
    logic            timed_out;
    art_pkg::entry_t upd_entry;
    logic            nd_done;

    function automatic logic [AW-1:0] slot_addr(input logic [NW-1:0] nd,
                                                 input logic [CW-1:0] idx);
        int a;
        begin
            a = int'(nd) * PENDING_DEPTH + int'(idx);
            return a[AW-1:0];
        end
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign nd_done  = (nd_reg == NCW'(NUM_NODES));
    assign cur_node = (cmd_reg == art_pkg::CMD_TICK) ? nd_reg[NW-1:0] : node_reg[NW-1:0];
    assign cur_cnt  = cnt_reg[cur_node];
    assign ram_rdata = art_pkg::entry_t'(ram_rbits);

    assign timed_out = (tick_reg - ram_rdata.start_tick) > {16'd0, timeout_reg};

    // high in the cycles where the sequencer loads a result into the output register
    always_comb begin
        unique case (state_reg)
            ST_SEND:    out_load = out_free;
            ST_ACK_RD:  out_load = out_free && (!in_range_reg || idx_reg == cur_cnt);
            ST_ACK_CMP: out_load = out_free && (ram_rdata.sequence_num == aseq_reg);
            ST_TK_NODE: out_load = out_free && nd_done;
            ST_TK_RES:  out_load = out_free && (rs_pend_reg || dc_pend_reg);
            default:    out_load = 1'b0;
        endcase
    end

    always_comb begin
        upd_entry = ram_rdata;
        if (ram_rdata.tries != 8'hFF) begin
            upd_entry.tries = ram_rdata.tries + 8'd1;
        end
        upd_entry.start_tick = tick_reg;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = '0;
        ram_raddr = '0;
        ram_wdata = ram_rdata;
        unique case (state_reg)
            ST_SEND: begin
                if (out_free && in_range_reg && code_reg != ack_code_reg
                        && cur_cnt != CW'(PENDING_DEPTH)) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_addr(cur_node, cur_cnt);
                    ram_wdata = '{sequence_num: seq_reg, code: code_reg,
                                  param_first: p1_reg, param_second: p2_reg,
                                  param_third: p3_reg, start_tick: tick_reg, tries: 8'd0};
                end
            end
            ST_ACK_RD: begin
                if (in_range_reg && idx_reg != cur_cnt) begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_addr(cur_node, idx_reg);
                end
            end
            ST_SH_RD: begin
                ram_re    = 1'b1;
                ram_raddr = slot_addr(cur_node, idx_reg + CW'(1));
            end
            ST_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = slot_addr(cur_node, idx_reg);
            end
            ST_TK_NODE: begin
                if (!nd_done && !disc_reg[cur_node] && cur_cnt != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_addr(cur_node, '0);
                end
            end
            ST_TK_CMP: begin
                if (timed_out) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_addr(cur_node, '0);
                    ram_wdata = upd_entry;
                end
            end
            default: ;
        endcase
    end

    art_ram #(
        .WIDTH (art_pkg::ENTRY_W),
        .DEPTH (NSLOTS)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rbits)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            disc_reg     <= '0;
            tick_reg     <= '0;
            seq_reg      <= '0;
            timeout_reg  <= 16'd2;
            retry_reg    <= 8'd3;
            ack_code_reg <= 8'd0;
            takeoff_reg  <= 8'd1;
            land_reg     <= 8'd2;
            cmd_reg      <= art_pkg::CMD_SEND;
            rs_pend_reg  <= 1'b0;
            dc_pend_reg  <= 1'b0;
            for (int i = 0; i < NUM_NODES; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    art_pkg::REG_TIMEOUT_TICKS:    timeout_reg  <= cfg_wdata;
                    art_pkg::REG_RETRY_LIMIT:      retry_reg    <= cfg_wdata[7:0];
                    art_pkg::REG_ACK_CODE:         ack_code_reg <= cfg_wdata[7:0];
                    art_pkg::REG_TAKEOFF_CODE:     takeoff_reg  <= cfg_wdata[7:0];
                    art_pkg::REG_LAND_CODE:        land_reg     <= cfg_wdata[7:0];
                    art_pkg::REG_INITIAL_SEQUENCE: seq_reg      <= cfg_wdata;
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        cmd_reg      <= s_cmd;
                        node_reg     <= s_node_id;
                        in_range_reg <= (s_node_id < 8'(NUM_NODES));
                        aseq_reg     <= s_ack_sequence;
                        code_reg     <= s_command_code;
                        p1_reg       <= s_param_first;
                        p2_reg       <= s_param_second;
                        p3_reg       <= s_param_third;
                        idx_reg      <= '0;
                        nd_reg       <= '0;
                        case (s_cmd)
                            art_pkg::CMD_SEND: state_reg <= ST_SEND;
                            art_pkg::CMD_ACK:  state_reg <= ST_ACK_RD;
                            art_pkg::CMD_TICK: begin
                                tick_reg  <= tick_reg + 32'd1;
                                state_reg <= ST_TK_NODE;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SEND: begin
                    if (out_free) begin
                        if (!in_range_reg) begin
                            out_reg <= '{event_res: art_pkg::EV_REJECTED,
                                         event_node: node_reg, event_sequence: '0,
                                         event_code: code_reg, param_first: '0,
                                         param_second: '0, param_third: '0,
                                         tries_so_far: 8'd0, last_of_run: 1'b1};
                        end else if (code_reg == ack_code_reg) begin
                            out_reg <= '{event_res: art_pkg::EV_PASSTHROUGH,
                                         event_node: node_reg, event_sequence: '0,
                                         event_code: code_reg, param_first: p1_reg,
                                         param_second: p2_reg, param_third: p3_reg,
                                         tries_so_far: 8'd0, last_of_run: 1'b1};
                        end else begin
                            out_reg <= '{event_res: (cur_cnt == CW'(PENDING_DEPTH))
                                                    ? art_pkg::EV_FULL
                                                    : art_pkg::EV_TRACKED,
                                         event_node: node_reg, event_sequence: seq_reg,
                                         event_code: code_reg, param_first: p1_reg,
                                         param_second: p2_reg, param_third: p3_reg,
                                         tries_so_far: 8'd0, last_of_run: 1'b1};
                            if (cur_cnt != CW'(PENDING_DEPTH)) begin
                                cnt_reg[cur_node] <= cur_cnt + CW'(1);
                                seq_reg <= seq_reg + 16'd1;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ACK_RD: begin
                    if (!in_range_reg || idx_reg == cur_cnt) begin
                        if (out_free) begin
                            out_reg <= '{event_res: art_pkg::EV_ACK_MISS,
                                         event_node: node_reg, event_sequence: aseq_reg,
                                         event_code: 8'd0, param_first: '0,
                                         param_second: '0, param_third: '0,
                                         tries_so_far: 8'd0, last_of_run: 1'b1};
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        state_reg <= ST_ACK_CMP;
                    end
                end
                ST_ACK_CMP: begin
                    if (ram_rdata.sequence_num == aseq_reg) begin
                        if (out_free) begin
                            out_reg <= '{event_res: art_pkg::EV_ACK_HIT,
                                         event_node: node_reg,
                                         event_sequence: ram_rdata.sequence_num,
                                         event_code: ram_rdata.code,
                                         param_first: ram_rdata.param_first,
                                         param_second: ram_rdata.param_second,
                                         param_third: ram_rdata.param_third,
                                         tries_so_far: ram_rdata.tries, last_of_run: 1'b1};
                            disc_reg[cur_node] <= 1'b0;
                            state_reg <= ST_SH_CHK;
                        end
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= ST_ACK_RD;
                    end
                end
                ST_SH_CHK: begin
                    // close the gap left by the removed entry
                    if ((CW+1)'(idx_reg) + (CW+1)'(1) < (CW+1)'(cur_cnt)) begin
                        state_reg <= ST_SH_RD;
                    end else begin
                        cnt_reg[cur_node] <= cur_cnt - CW'(1);
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SH_RD: begin
                    state_reg <= ST_SH_WR;
                end
                ST_SH_WR: begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= ST_SH_CHK;
                end
                ST_TK_NODE: begin
                    if (nd_done) begin
                        if (out_free) begin
                            out_reg <= '{event_res: art_pkg::EV_TICK_DONE, event_node: 8'd0,
                                         event_sequence: '0, event_code: 8'd0,
                                         param_first: '0, param_second: '0,
                                         param_third: '0, tries_so_far: 8'd0,
                                         last_of_run: 1'b1};
                            state_reg <= ST_IDLE;
                        end
                    end else if (disc_reg[cur_node] || cur_cnt == '0) begin
                        nd_reg <= nd_reg + NCW'(1);
                    end else begin
                        state_reg <= ST_TK_CMP;
                    end
                end
                ST_TK_CMP: begin
                    if (timed_out) begin
                        ent_reg     <= upd_entry;
                        rs_pend_reg <= (ram_rdata.code == takeoff_reg)
                                    || (ram_rdata.code == land_reg);
                        dc_pend_reg <= (upd_entry.tries > retry_reg);
                        state_reg   <= ST_TK_RES;
                    end else begin
                        nd_reg    <= nd_reg + NCW'(1);
                        state_reg <= ST_TK_NODE;
                    end
                end
                ST_TK_RES: begin
                    if (rs_pend_reg || dc_pend_reg) begin
                        if (out_free) begin
                            out_reg <= '{event_res: rs_pend_reg ? art_pkg::EV_RESEND
                                                                : art_pkg::EV_DISCONNECT,
                                         event_node: 8'(nd_reg),
                                         event_sequence: ent_reg.sequence_num,
                                         event_code: ent_reg.code,
                                         param_first: ent_reg.param_first,
                                         param_second: ent_reg.param_second,
                                         param_third: ent_reg.param_third,
                                         tries_so_far: ent_reg.tries, last_of_run: 1'b0};
                            if (rs_pend_reg) begin
                                rs_pend_reg <= 1'b0;
                            end else begin
                                dc_pend_reg <= 1'b0;
                                disc_reg[cur_node] <= 1'b1;
                            end
                        end
                    end else begin
                        nd_reg    <= nd_reg + NCW'(1);
                        state_reg <= ST_TK_NODE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_event_res        = out_reg.event_res;
    assign m_event_node       = out_reg.event_node;
    assign m_event_sequence   = out_reg.event_sequence;
    assign m_event_code       = out_reg.event_code;
    assign m_out_param_first  = out_reg.param_first;
    assign m_out_param_second = out_reg.param_second;
    assign m_out_param_third  = out_reg.param_third;
    assign m_tries_so_far     = out_reg.tries_so_far;
    assign m_last_of_run      = out_reg.last_of_run;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_cnt <= CW'(PENDING_DEPTH))
        else $error("fifo count beyond depth");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_cmd == art_pkg::CMD_SEND || s_cmd == art_pkg::CMD_ACK
                      || s_cmd == art_pkg::CMD_TICK)) |=> !s_ready)
        else $error("ready while an item is in work");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(out_reg))
        else $error("pending result overwritten");
    a_no_rw_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("entry ram read and write in one cycle");
`endif

endmodule

`default_nettype wire
